FILE: design/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// shared constants, types and helpers of the keypad code lock
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kcl_pkg;

  localparam int unsigned MAX_DIGITS = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned OUT_W      = 3;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [LEN_W-1:0]  LEN_RESET    = 4'd4;
  localparam logic [CODE_W-1:0] PRESET_RESET = 32'd17185;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_CODE = 1'd1;

  localparam logic [KEY_W-1:0] KEY_A    = 8'h41;
  localparam logic [KEY_W-1:0] KEY_ZERO = 8'h30;
  localparam logic [KEY_W-1:0] KEY_NINE = 8'h39;

  localparam logic [OUT_W-1:0] OUT_GRANTED   = 3'd0;
  localparam logic [OUT_W-1:0] OUT_DENIED    = 3'd1;
  localparam logic [OUT_W-1:0] OUT_WRONG_OLD = 3'd2;
  localparam logic [OUT_W-1:0] OUT_UPDATED   = 3'd3;
  localparam logic [OUT_W-1:0] OUT_OLD_OK    = 3'd4;

  typedef enum logic [2:0] {
    MODE_VERIFY = 3'b001,
    MODE_OLD    = 3'b010,
    MODE_NEW    = 3'b100
  } mode_t;

  // classified key request
  typedef struct packed {
    logic               is_digit;
    logic               is_a;
    logic [DIGIT_W-1:0] digit;
  } key_class_t;

  typedef struct packed {
    logic [LEN_W-1:0]  code_length;
    logic              load;
    logic [CODE_W-1:0] preset;
  } cfg_t;

  function automatic logic [DIGIT_W-1:0] preset_digit(input logic [CODE_W-1:0] code,
                                                      input int unsigned i);
    logic [DIGIT_W-1:0] d;
    d = '0;
    if (i < 8) begin
      d = DIGIT_W'(code >> (DIGIT_W * i));
    end
    return d;
  endfunction

endpackage

FILE: design/kcl_front.sv
// ----------------------------------------------------------------------------
// kcl_front
// accepts keypad characters and classifies them as digit, 'A' or other
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcl_front (
  input  logic                      push,
  input  logic                      full,
  input  logic [kcl_pkg::KEY_W-1:0] key,
  output logic                      wr,
  output kcl_pkg::key_class_t       cls
);

  logic is_digit;

  assign is_digit = (key >= kcl_pkg::KEY_ZERO) && (key <= kcl_pkg::KEY_NINE);
  assign wr       = push && !full;

  always_comb begin
    cls.is_digit = is_digit;
    cls.is_a     = (key == kcl_pkg::KEY_A);
    cls.digit    = is_digit ? kcl_pkg::DIGIT_W'(key - kcl_pkg::KEY_ZERO) : '0;
  end

endmodule

FILE: design/kcl_queue.sv
// ----------------------------------------------------------------------------
// kcl_queue
// two-entry queue of classified key requests between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcl_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  kcl_pkg::key_class_t wr_cls,
  output logic                full,
  output logic                valid,
  output kcl_pkg::key_class_t rd_cls,
  input  logic                take
);

  kcl_pkg::key_class_t slots [2];
  logic                wptr;
  logic                rptr;
  logic [1:0]          count;
  logic                do_rd;

  assign full   = (count == 2'd2);
  assign valid  = (count != 2'd0);
  assign rd_cls = slots[rptr];
  assign do_rd  = take && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= !wptr;
      end
      if (do_rd) begin
        rptr <= !rptr;
      end
      count <= count + 2'(wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_cls;
    end
  end

endmodule

FILE: design/kcl_back.sv
// ----------------------------------------------------------------------------
// kcl_back
// entry buffer, stored code and mode; compares entries and queues outcomes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcl_back (
  input  logic                      clk,
  input  logic                      rst,
  input  kcl_pkg::cfg_t             cfg,
  input  logic                      q_valid,
  input  kcl_pkg::key_class_t       q_cls,
  output logic                      take,
  input  logic                      pop,
  output logic                      empty,
  output logic [kcl_pkg::OUT_W-1:0] outcome
);

  localparam int unsigned MD = kcl_pkg::MAX_DIGITS;
  localparam int unsigned DW = kcl_pkg::DIGIT_W;
  localparam int unsigned IW = kcl_pkg::IDX_W;
  localparam int unsigned CW = kcl_pkg::CNT_W;

  kcl_pkg::mode_t    mode;
  kcl_pkg::mode_t    mode_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              bad;
  logic              bad_next;
  logic [DW-1:0]     entry [MD];
  logic [DW-1:0]     entry_new [MD];
  logic [DW-1:0]     stored [MD];
  logic [CW-1:0]     n;
  logic              is_verify;
  logic              wr_en;
  logic [IW-1:0]     slot;
  logic [CW-1:0]     cnt_n;
  logic              done;
  logic              match;
  logic              res_valid;
  logic [kcl_pkg::OUT_W-1:0] res;

  logic [kcl_pkg::OUT_W-1:0] ob [2];
  logic                      ob_wptr;
  logic                      ob_rptr;
  logic [1:0]                ob_count;
  logic                      ob_wr;
  logic                      ob_rd;

  assign take      = q_valid && (ob_count != 2'd2);
  assign is_verify = !((mode == kcl_pkg::MODE_OLD) || (mode == kcl_pkg::MODE_NEW));

  always_comb begin
    if (cfg.code_length == '0) begin
      n = CW'(1);
    end else if (32'(cfg.code_length) > MD) begin
      n = CW'(MD);
    end else begin
      n = CW'(cfg.code_length);
    end
  end

  always_comb begin
    mode_next = mode;
    bad_next  = bad;
    wr_en     = 1'b0;
    slot      = '0;
    cnt_n     = count;
    if (is_verify && count == '0) begin
      if (q_cls.is_a) begin
        mode_next = kcl_pkg::MODE_OLD;
        bad_next  = 1'b0;
      end else begin
        bad_next = !q_cls.is_digit;
        wr_en    = 1'b1;
        cnt_n    = CW'(1);
      end
    end else if (q_cls.is_digit) begin
      wr_en = 1'b1;
      if (32'(count) >= MD - 1) begin
        slot = IW'(MD - 1);
      end else begin
        slot = IW'(count);
      end
      cnt_n = CW'(slot) + CW'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < MD; i++) begin
      entry_new[i] = (wr_en && slot == IW'(i)) ? q_cls.digit : entry[i];
    end
  end

  always_comb begin
    match = !bad_next;
    for (int i = 0; i < MD; i++) begin
      if (i < 32'(n) && entry_new[i] != stored[i]) begin
        match = 1'b0;
      end
    end
  end

  assign done = wr_en && (cnt_n >= n);

  always_comb begin
    res_valid = done;
    res       = kcl_pkg::OUT_DENIED;
    case (mode)
      kcl_pkg::MODE_OLD: begin
        res = match ? kcl_pkg::OUT_OLD_OK : kcl_pkg::OUT_WRONG_OLD;
      end
      kcl_pkg::MODE_NEW: begin
        res = kcl_pkg::OUT_UPDATED;
      end
      default: begin
        res = match ? kcl_pkg::OUT_GRANTED : kcl_pkg::OUT_DENIED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= kcl_pkg::MODE_VERIFY;
      count <= '0;
      bad   <= 1'b0;
    end else if (take) begin
      if (done) begin
        count <= '0;
        bad   <= 1'b0;
        case (mode)
          kcl_pkg::MODE_OLD: mode <= match ? kcl_pkg::MODE_NEW : kcl_pkg::MODE_VERIFY;
          default:           mode <= kcl_pkg::MODE_VERIFY;
        endcase
      end else begin
        count <= cnt_n;
        bad   <= bad_next;
        mode  <= mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      entry[slot] <= q_cls.digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MD; i++) begin
        stored[i] <= kcl_pkg::preset_digit(kcl_pkg::PRESET_RESET, i);
      end
    end else if (cfg.load) begin
      for (int i = 0; i < MD; i++) begin
        stored[i] <= kcl_pkg::preset_digit(cfg.preset, i);
      end
    end else if (take && done && mode == kcl_pkg::MODE_NEW) begin
      for (int i = 0; i < MD; i++) begin
        if (i < 32'(n)) begin
          stored[i] <= entry_new[i];
        end
      end
    end
  end

  // result queue
  assign ob_wr   = take && res_valid;
  assign ob_rd   = pop && (ob_count != 2'd0);
  assign empty   = (ob_count == 2'd0);
  assign outcome = ob[ob_rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wptr  <= 1'b0;
      ob_rptr  <= 1'b0;
      ob_count <= 2'd0;
    end else begin
      if (ob_wr) begin
        ob_wptr <= !ob_wptr;
      end
      if (ob_rd) begin
        ob_rptr <= !ob_rptr;
      end
      ob_count <= ob_count + 2'(ob_wr) - 2'(ob_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (ob_wr) begin
      ob[ob_wptr] <= res;
    end
  end

endmodule

FILE: design/keypad_code_lock_core.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_core
// keypad combination lock with code change
//
//   channel   direction  handshake          payload
//   keys      in         push / full        key[7:0]
//   results   out        empty / pop        outcome[2:0]
//   config    in         cfg_write          cfg_index[0], cfg_data[31:0]
//
// one key a cycle sustained while the back end does not stall; a result passes
// through the input queue, then the back-end update into the result queue
// both queues hold two requests; full rises only when the back end stalls
// on a full result queue, i.e. while pop stays low
// synchronous reset restores code length 4 and the preset code, no sweep
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_code_lock_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [kcl_pkg::KEY_W-1:0]     key,
  output logic                          empty,
  input  logic                          pop,
  output logic [kcl_pkg::OUT_W-1:0]     outcome,
  input  logic                          cfg_write,
  input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcl_pkg::CODE_W-1:0]    cfg_data
);

  logic [kcl_pkg::LEN_W-1:0] code_length;
  kcl_pkg::cfg_t             cfg;
  logic                      wr;
  kcl_pkg::key_class_t       wr_cls;
  logic                      q_valid;
  kcl_pkg::key_class_t       q_cls;
  logic                      take;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= kcl_pkg::LEN_RESET;
    end else if (cfg_write && cfg_index == kcl_pkg::REG_CODE_LENGTH) begin
      code_length <= cfg_data[kcl_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    cfg.code_length = code_length;
    cfg.load        = cfg_write && (cfg_index == kcl_pkg::REG_PRESET_CODE);
    cfg.preset      = cfg_data;
  end

  kcl_front u_front (
    .push (push),
    .full (full),
    .key  (key),
    .wr   (wr),
    .cls  (wr_cls)
  );

  kcl_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .wr_cls (wr_cls),
    .full   (full),
    .valid  (q_valid),
    .rd_cls (q_cls),
    .take   (take)
  );

  kcl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_cls   (q_cls),
    .take    (take),
    .pop     (pop),
    .empty   (empty),
    .outcome (outcome)
  );

  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not clear after reset");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(take))
    else $error("result appeared without a back-end request");

  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !take && !pop) |=> q_valid)
    else $error("queued request lost while back end stalled");

  a_take_valid: assert property (@(posedge clk) take |-> q_valid)
    else $error("back end took from an empty queue");

endmodule
